@@ rtl/core/cvc_pkg.sv @@
`timescale 1ns / 1ps
// cvc_pkg: shared widths, state encodings and status structs for the coffee
// vending controller core. No dependencies.
package cvc_pkg;

    localparam int BALANCE_BITS = 10;
    localparam int OUT_W        = 10;
    localparam int PRICE_W      = 10;
    localparam int TICK_W       = 8;
    localparam int COIN_W       = 8;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_IDX_W    = 2;
    // wide enough for balance plus a coin and for compares against price
    localparam int WIDE_W = ((BALANCE_BITS > PRICE_W) ? BALANCE_BITS : PRICE_W) + 1;

    localparam logic [BALANCE_BITS-1:0] BAL_MAX   = '1;
    localparam logic [PRICE_W-1:0]      PRICE_RST = PRICE_W'(50);
    localparam logic [TICK_W-1:0]       CUP_RST   = TICK_W'(1);
    localparam logic [TICK_W-1:0]       BREW_RST  = TICK_W'(12);
    localparam logic [TICK_W-1:0]       MILK_RST  = TICK_W'(12);

    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_CUP    = 4'b0010,
        PH_COFFEE = 4'b0100,
        PH_MILK   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        WM_MONEY = 2'b01,
        WM_SERVE = 2'b10
    } wallet_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRICE  = 2'd0,
        CFG_CUP    = 2'd1,
        CFG_COFFEE = 2'd2,
        CFG_MILK   = 2'd3
    } cfg_reg_t;

    localparam logic [1:0] DPH_WAIT   = 2'd0;
    localparam logic [1:0] DPH_CUP    = 2'd1;
    localparam logic [1:0] DPH_COFFEE = 2'd2;
    localparam logic [1:0] DPH_MILK   = 2'd3;

    typedef struct packed {
        logic milk;
        logic coffee;
        logic cup;
        logic lamp;
    } drive_t;

    // sequencer view after this tick, handed to the wallet and the result
    typedef struct packed {
        phase_t phase;
        drive_t drive;
        logic   busy_set;
        logic   served_set;
    } seq_status_t;

    typedef struct packed {
        logic             serve;
        logic             pulse;
        logic [OUT_W-1:0] amount;
        logic [OUT_W-1:0] balance;
    } wallet_status_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_WAIT:   code = DPH_WAIT;
            PH_CUP:    code = DPH_CUP;
            PH_COFFEE: code = DPH_COFFEE;
            PH_MILK:   code = DPH_MILK;
            default:   code = DPH_WAIT;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/cvc_seq.sv @@
`timescale 1ns / 1ps
// cvc_seq: dispense sequencer (waiting, cup, coffee, milk) with its countdown.
// Depends on cvc_pkg.
module cvc_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       brew,
    input  logic                       paid,
    input  logic [cvc_pkg::TICK_W-1:0] cup_ticks,
    input  logic [cvc_pkg::TICK_W-1:0] coffee_ticks,
    input  logic [cvc_pkg::TICK_W-1:0] milk_ticks,
    output cvc_pkg::seq_status_t       seq_next
);
    import cvc_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  cnt_reg, cnt_next;
    drive_t             drive_reg, drive_next;
    logic               busy_set, served_set;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        drive_next = drive_reg;
        busy_set   = 1'b0;
        served_set = 1'b0;
        if (phase_reg == PH_WAIT) begin
            if (brew && paid) begin
                busy_set   = 1'b1;
                drive_next = '{milk: 1'b0, coffee: 1'b0, cup: 1'b1, lamp: 1'b0};
                cnt_next   = cup_ticks;
                phase_next = PH_CUP;
            end
        end else if (cnt_reg > TICK_W'(1)) begin
            cnt_next = cnt_reg - TICK_W'(1);
        end else begin
            // a loaded count of zero ends the phase like a count of one
            case (phase_reg)
                PH_CUP: begin
                    drive_next = '{milk: 1'b0, coffee: 1'b1, cup: 1'b0, lamp: 1'b0};
                    cnt_next   = coffee_ticks;
                    phase_next = PH_COFFEE;
                end
                PH_COFFEE: begin
                    drive_next = '{milk: 1'b1, coffee: 1'b0, cup: 1'b0, lamp: 1'b0};
                    cnt_next   = milk_ticks;
                    phase_next = PH_MILK;
                end
                default: begin
                    drive_next = '{milk: 1'b0, coffee: 1'b0, cup: 1'b0, lamp: 1'b1};
                    cnt_next   = '0;
                    served_set = 1'b1;
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            cnt_reg   <= '0;
            drive_reg <= '{milk: 1'b0, coffee: 1'b0, cup: 1'b0, lamp: 1'b1};
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            drive_reg <= drive_next;
        end
    end

    assign seq_next = '{phase: phase_next, drive: drive_next,
                        busy_set: busy_set, served_set: served_set};

endmodule

@@ rtl/core/cvc_wallet.sv @@
`timescale 1ns / 1ps
// cvc_wallet: saturating coin balance, paid/served/busy flags, change and refund.
// Depends on cvc_pkg; runs after cvc_seq within the same tick.
module cvc_wallet (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        coin,
    input  logic [cvc_pkg::COIN_W-1:0]  coin_value,
    input  logic                        refund,
    input  logic [cvc_pkg::PRICE_W-1:0] price,
    input  cvc_pkg::seq_status_t        seq,
    output logic                        paid,
    output cvc_pkg::wallet_status_t     wallet_next
);
    import cvc_pkg::*;

    wallet_mode_t            mode_reg, mode_next;
    logic [BALANCE_BITS-1:0] bal_reg, bal_next, bal_sat, bal_work;
    logic                    paid_reg, paid_next;
    logic                    served_reg, served_next;
    logic                    busy_reg, busy_next;
    logic [WIDE_W-1:0]       sum, price_w, diff;
    logic                    busy_now, served_now, enough;
    logic                    pulse;
    logic [BALANCE_BITS-1:0] amount;

    assign price_w    = WIDE_W'(price);
    assign sum        = WIDE_W'(bal_reg) + WIDE_W'(coin_value);
    assign bal_sat    = (sum > WIDE_W'(BAL_MAX)) ? BAL_MAX : sum[BALANCE_BITS-1:0];
    assign enough     = WIDE_W'(bal_sat) >= price_w;
    assign bal_work   = coin ? bal_sat : bal_reg;
    assign diff       = WIDE_W'(bal_reg) - price_w;
    // flags as the sequencer left them this tick
    assign busy_now   = busy_reg | seq.busy_set;
    assign served_now = served_reg | seq.served_set;

    always_comb begin
        mode_next   = mode_reg;
        bal_next    = bal_reg;
        paid_next   = paid_reg;
        served_next = served_now;
        busy_next   = busy_now;
        pulse       = 1'b0;
        amount      = '0;
        case (mode_reg)
            WM_MONEY: begin
                if (coin) begin
                    bal_next = bal_sat;
                    if (enough) begin
                        paid_next = 1'b1;
                        mode_next = WM_SERVE;
                    end
                end
            end
            default: begin
                if (served_now) begin
                    pulse       = 1'b1;
                    // price may have been raised since payment
                    amount      = (WIDE_W'(bal_reg) >= price_w) ?
                                  diff[BALANCE_BITS-1:0] : '0;
                    bal_next    = '0;
                    paid_next   = 1'b0;
                    served_next = 1'b0;
                    busy_next   = 1'b0;
                    mode_next   = WM_MONEY;
                end else begin
                    bal_next = bal_work;
                    if (!(coin && enough) && refund && !busy_now) begin
                        pulse       = 1'b1;
                        amount      = bal_work;
                        bal_next    = '0;
                        paid_next   = 1'b0;
                        served_next = 1'b0;
                        mode_next   = WM_MONEY;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= WM_MONEY;
            bal_reg    <= '0;
            paid_reg   <= 1'b0;
            served_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end else if (step) begin
            mode_reg   <= mode_next;
            bal_reg    <= bal_next;
            paid_reg   <= paid_next;
            served_reg <= served_next;
            busy_reg   <= busy_next;
        end
    end

    assign paid = paid_reg;

    logic [WIDE_W-1:0] amount_w, bal_w;
    assign amount_w = WIDE_W'(amount);
    assign bal_w    = WIDE_W'(bal_next);

    assign wallet_next = '{serve: (mode_next == WM_SERVE), pulse: pulse,
                           amount: amount_w[OUT_W-1:0], balance: bal_w[OUT_W-1:0]};

endmodule

@@ rtl/core/coffee_vending_controller_core.sv @@
`timescale 1ns / 1ps
// coffee_vending_controller_core: top level, config registers and result register.
// Depends on cvc_pkg, cvc_seq and cvc_wallet.
//
// Each input beat on s_* is one 250 ms tick carrying the brew button, a coin
// event with its value and the refund button. Each accepted beat yields
// exactly one result beat on m_* with the lamp and valve drives, a change
// pulse and amount, the balance after the tick and both phase codes.
// The dispense sequencer steps first, then the wallet, on the same beat.
// The result appears in the output register the cycle after the input beat
// is accepted. Throughput is one beat per cycle while the receiver takes each
// result, set by the single output register; all tick logic sits in front of it.
// When the receiver stalls, the result holds in the output register and
// s_ready stays low until it is taken; s_ready rises again in the cycle the
// waiting result is taken, so streaming continues without a bubble.
// The configuration port (cfg_wr_en, cfg_index, cfg_wr_data) writes price or
// one of the three valve tick counts, chosen by cfg_index; write it only while idle.
// Reset (aresetn low, synchronous) restores default config, empties the
// output register and returns sequencer and wallet to waiting, balance zero.
module coffee_vending_controller_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_brew_button,
    input  logic                           s_coin_inserted,
    input  logic [cvc_pkg::COIN_W-1:0]     s_coin_value,
    input  logic                           s_refund_button,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ready_lamp,
    output logic                           m_cup_valve,
    output logic                           m_coffee_valve,
    output logic                           m_milk_valve,
    output logic                           m_change_pulse,
    output logic [cvc_pkg::OUT_W-1:0]      m_change_amount,
    output logic [cvc_pkg::OUT_W-1:0]      m_balance_now,
    output logic [1:0]                     m_dispense_phase,
    output logic                           m_wallet_phase
);
    import cvc_pkg::*;

    logic [PRICE_W-1:0] price_reg;
    logic [TICK_W-1:0]  cup_ticks_reg, coffee_ticks_reg, milk_ticks_reg;
    logic               m_valid_reg, m_valid_next;
    logic               step, paid;
    seq_status_t        seq_next;
    wallet_status_t     wallet_next;

    drive_t             drive_reg;
    logic               pulse_reg;
    logic [OUT_W-1:0]   amount_reg, balance_reg;
    logic [1:0]         dphase_reg;
    logic               wphase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_reg        <= PRICE_RST;
            cup_ticks_reg    <= CUP_RST;
            coffee_ticks_reg <= BREW_RST;
            milk_ticks_reg   <= MILK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PRICE:  price_reg        <= cfg_wr_data[PRICE_W-1:0];
                CFG_CUP:    cup_ticks_reg    <= cfg_wr_data[TICK_W-1:0];
                CFG_COFFEE: coffee_ticks_reg <= cfg_wr_data[TICK_W-1:0];
                CFG_MILK:   milk_ticks_reg   <= cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    cvc_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .brew         (s_brew_button),
        .paid         (paid),
        .cup_ticks    (cup_ticks_reg),
        .coffee_ticks (coffee_ticks_reg),
        .milk_ticks   (milk_ticks_reg),
        .seq_next     (seq_next)
    );

    cvc_wallet u_wallet (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .coin        (s_coin_inserted),
        .coin_value  (s_coin_value),
        .refund      (s_refund_button),
        .price       (price_reg),
        .seq         (seq_next),
        .paid        (paid),
        .wallet_next (wallet_next)
    );

    always_comb begin
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only on an accepted beat
    always_ff @(posedge aclk) begin
        if (step) begin
            drive_reg   <= seq_next.drive;
            dphase_reg  <= phase_code(seq_next.phase);
            pulse_reg   <= wallet_next.pulse;
            amount_reg  <= wallet_next.amount;
            balance_reg <= wallet_next.balance;
            wphase_reg  <= wallet_next.serve;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ready_lamp     = drive_reg.lamp;
    assign m_cup_valve      = drive_reg.cup;
    assign m_coffee_valve   = drive_reg.coffee;
    assign m_milk_valve     = drive_reg.milk;
    assign m_change_pulse   = pulse_reg;
    assign m_change_amount  = amount_reg;
    assign m_balance_now    = balance_reg;
    assign m_dispense_phase = dphase_reg;
    assign m_wallet_phase   = wphase_reg;

endmodule

@@ rtl/core/cvc_checker.sv @@
`timescale 1ns / 1ps
// cvc_checker: port-level assertions for coffee_vending_controller_core, with bind.
// Depends on cvc_pkg.
module cvc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_ready_lamp,
    input logic                           m_cup_valve,
    input logic                           m_coffee_valve,
    input logic                           m_milk_valve,
    input logic                           m_change_pulse,
    input logic [cvc_pkg::OUT_W-1:0]      m_change_amount,
    input logic [cvc_pkg::OUT_W-1:0]      m_balance_now,
    input logic [1:0]                     m_dispense_phase
);
    import cvc_pkg::*;

    // exactly one valve open, or the lamp alone when no valve is open
    a_valves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_ready_lamp, m_cup_valve, m_coffee_valve, m_milk_valve}))
        else $error("valve and lamp drives not one-hot");

    // lamp tracks the waiting phase of the sequencer
    a_lamp_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ready_lamp == (m_dispense_phase == DPH_WAIT)))
        else $error("ready lamp disagrees with dispense phase");

    // no change amount without a change pulse
    a_amount: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_change_pulse) |-> (m_change_amount == '0))
        else $error("change amount without pulse");

    // a stalled result beat holds its balance
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_balance_now)))
        else $error("stalled result changed");

endmodule

bind coffee_vending_controller_core cvc_checker u_cvc_checker (.*);
